>>> sv/gniw_pkg.sv
`timescale 1ns / 1ps
package gniw_pkg;
    localparam int MAX_PIXELS  = 1024;
    localparam int COORD_BITS  = 16;
    localparam int IDX_W       = 11;
    localparam int ADDR_W      = $clog2(MAX_PIXELS);
    localparam int DIFF_W      = COORD_BITS + 1;
    localparam int SQ_W        = 2 * DIFF_W;
    localparam int DIST_W      = SQ_W + 1;
    localparam int TOL_W       = 16;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [IDX_W-1:0] NO_NEIGHBOR = {IDX_W{1'b1}};

    typedef logic [1:0] dir_t;
    localparam dir_t DIR_UP    = 2'd0;
    localparam dir_t DIR_DOWN  = 2'd1;
    localparam dir_t DIR_LEFT  = 2'd2;
    localparam dir_t DIR_RIGHT = 2'd3;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_LOAD   = 2'd0;
    localparam cmd_t CMD_OFFSET = 2'd1;
    localparam cmd_t CMD_ALT_X  = 2'd2;
    localparam cmd_t CMD_ALT_Y  = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] CFG_RECT_MODE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PPR       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PCOUNT    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_REVERSE   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOL       = 3'd4;

    // start/operands into the squarer
    typedef struct packed {
        logic              start;
        logic [DIFF_W-1:0] dx;
        logic [DIFF_W-1:0] dy;
    } sq_req_t;
endpackage

>>> sv/gniw_sqdist.sv
`timescale 1ns / 1ps
module gniw_sqdist
    import gniw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  sq_req_t           req,
    output logic              done,
    output logic [DIST_W-1:0] sum
);
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SQX  = 2'd1;
    localparam logic [1:0] PH_SQY  = 2'd2;
    localparam logic [1:0] PH_SUM  = 2'd3;

    logic [1:0]        phase_reg, phase_next;
    logic [DIFF_W-1:0] op_reg, dy_reg;
    logic [SQ_W-1:0]   prod_reg, acc_reg;
    logic [DIST_W-1:0] sum_reg;
    logic              done_reg, done_next;

    always_comb begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        case (phase_reg)
            PH_IDLE: if (req.start) phase_next = PH_SQX;
            PH_SQX:  phase_next = PH_SQY;
            PH_SQY:  phase_next = PH_SUM;
            PH_SUM: begin
                phase_next = PH_IDLE;
                done_next  = 1'b1;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        // one multiplier, used for dx then dy
        case (phase_reg)
            PH_IDLE: begin
                op_reg <= req.dx;
                dy_reg <= req.dy;
            end
            PH_SQX: begin
                prod_reg <= op_reg * op_reg;
                op_reg   <= dy_reg;
            end
            PH_SQY: begin
                acc_reg  <= prod_reg;
                prod_reg <= op_reg * op_reg;
            end
            PH_SUM:  sum_reg <= {1'b0, acc_reg} + {1'b0, prod_reg};
            default: ;
        endcase
    end

    assign done = done_reg;
    assign sum  = sum_reg;
endmodule

>>> sv/gniw_colrem.sv
`timescale 1ns / 1ps
module gniw_colrem
    import gniw_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [IDX_W-1:0] dividend,
    input  logic [IDX_W-1:0] divisor,
    output logic             done,
    output logic [IDX_W-1:0] rem
);
    localparam int CNT_W = $clog2(IDX_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] dvd_reg;
    logic [IDX_W:0]   rem_reg, trial, rem_step;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial     = {rem_reg[IDX_W-1:0], dvd_reg[IDX_W-1]};
        rem_step  = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (busy_reg) begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(IDX_W);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        if (busy_reg) begin
            rem_reg <= rem_step;
            dvd_reg <= {dvd_reg[IDX_W-2:0], 1'b0};
        end else if (start) begin
            rem_reg <= '0;
            dvd_reg <= dividend;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg[IDX_W-1:0];
endmodule

>>> sv/grid_neighbor_index_walker.sv
`timescale 1ns / 1ps
// Load request: the last load of a group starts a table build (one squared
// distance per pair through the squarer). Walk: grid steps, or table steps
// through a registered table read, after a column remainder in grid mode,
// with a turn from x to y steps; the result is handed off through an output
// register. One request at a time. Synchronous active-low reset;
// no clearing pass: entries at or above the last built group size read as no neighbour.
module grid_neighbor_index_walker
    import gniw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // command[1:0], point_x[17:2], point_y[33:18], start_index[44:34],
    // offset_x[55:45], offset_y[66:56], zero padding
    input  logic [71:0]           s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // end_index[10:0], walk_valid[11], zero padding
    output logic [15:0]           m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_BROW  = 4'd1;
    localparam logic [3:0] ST_BROWW = 4'd2;
    localparam logic [3:0] ST_BRD   = 4'd3;
    localparam logic [3:0] ST_BCAP  = 4'd4;
    localparam logic [3:0] ST_BDIST = 4'd5;
    localparam logic [3:0] ST_BWR   = 4'd6;
    localparam logic [3:0] ST_WCOL  = 4'd7;
    localparam logic [3:0] ST_WSTEP = 4'd8;
    localparam logic [3:0] ST_WTAB  = 4'd9;
    localparam logic [3:0] ST_FIN   = 4'd10;

    localparam int PT_W = 2 * COORD_BITS;

    // configuration
    logic             rect_reg, rev_reg;
    logic [IDX_W-1:0] ppr_reg, pcount_reg;
    logic [TOL_W-1:0] tol_reg;
    logic [IDX_W-1:0] n;

    // request fields
    cmd_t                   in_cmd;
    logic [COORD_BITS-1:0]  in_x, in_y;
    logic [IDX_W-1:0]       in_start;
    logic signed [IDX_W-1:0] in_ox, in_oy;
    logic                   s_acc;

    logic [3:0]       state_reg, state_next;
    logic [IDX_W-1:0] pl_reg, pl_next, pl_eff;
    logic [IDX_W-1:0] built_n_reg, built_n_next;
    logic [IDX_W-1:0] row_reg, row_next, j_reg, j_next, si, sj;

    // point store and neighbour tables
    logic [PT_W-1:0]   store_mem [MAX_PIXELS];
    logic [PT_W-1:0]   store_rd_reg;
    logic              store_we;
    logic [ADDR_W-1:0] store_waddr, store_raddr;
    logic [IDX_W-1:0]  tab_up_mem [MAX_PIXELS];
    logic [IDX_W-1:0]  tab_dn_mem [MAX_PIXELS];
    logic [IDX_W-1:0]  tab_lf_mem [MAX_PIXELS];
    logic [IDX_W-1:0]  tab_rt_mem [MAX_PIXELS];
    logic [IDX_W-1:0]  tab_rd_reg [4];
    logic              tab_we;
    logic [ADDR_W-1:0] tab_raddr;

    // build datapath
    logic [PT_W-1:0]   a_reg, a_next;
    logic [DIST_W-1:0] best_reg [4];
    logic [IDX_W-1:0]  who_reg [4], who_next [4];
    logic              best_we [4];
    logic [3:0]        cand_reg, cand_next;
    logic signed [COORD_BITS-1:0] ax, ay, bx, by;
    logic signed [DIFF_W-1:0]     dxs, dys;
    logic [DIFF_W-1:0] adx, ady;
    sq_req_t           sq_req;
    logic              sq_done;
    logic [DIST_W-1:0] sq_sum;

    // walk datapath
    logic [IDX_W-1:0] idx_reg, idx_next, cnt_reg, cnt_next, cnt2_reg, cnt2_next;
    logic [IDX_W-1:0] col_reg, col_next;
    dir_t             dir_reg, dir_next, dir2_reg, dir2_next;
    logic             col_start, col_done;
    logic [IDX_W-1:0] col_rem;
    logic [IDX_W-1:0] grid_nxt, col_step, tab_nxt;
    logic [IDX_W:0]   up_sum, rt_sum;

    // result
    logic             res_ok_reg, res_ok_next;
    logic [IDX_W-1:0] res_end_reg, res_end_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [IDX_W-1:0] m_end_reg;
    logic             m_ok_reg;
    logic             out_load;

    assign in_cmd   = s_tdata[1:0];
    assign in_x     = s_tdata[17:2];
    assign in_y     = s_tdata[33:18];
    assign in_start = s_tdata[44:34];
    assign in_ox    = s_tdata[55:45];
    assign in_oy    = s_tdata[66:56];

    assign n = (pcount_reg > IDX_W'(MAX_PIXELS)) ? IDX_W'(MAX_PIXELS) : pcount_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    assign si = rev_reg ? n - 1'b1 - row_reg : row_reg;
    assign sj = rev_reg ? n - 1'b1 - j_reg : j_reg;

    assign ax  = a_reg[COORD_BITS-1:0];
    assign ay  = a_reg[PT_W-1:COORD_BITS];
    assign bx  = store_rd_reg[COORD_BITS-1:0];
    assign by  = store_rd_reg[PT_W-1:COORD_BITS];
    assign dxs = DIFF_W'(ax) - DIFF_W'(bx);
    assign dys = DIFF_W'(ay) - DIFF_W'(by);
    assign adx = dxs[DIFF_W-1] ? DIFF_W'(-dxs) : DIFF_W'(dxs);
    assign ady = dys[DIFF_W-1] ? DIFF_W'(-dys) : DIFF_W'(dys);

    assign sq_req.start = (state_reg == ST_BCAP);
    assign sq_req.dx    = adx;
    assign sq_req.dy    = ady;

    gniw_sqdist u_sqdist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sq_req),
        .done    (sq_done),
        .sum     (sq_sum)
    );

    gniw_colrem u_colrem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (col_start),
        .dividend (in_start),
        .divisor  (ppr_reg),
        .done     (col_done),
        .rem      (col_rem)
    );

    // one grid step
    assign up_sum = {1'b0, idx_reg} + {1'b0, ppr_reg};
    assign rt_sum = {1'b0, idx_reg} + 1'b1;
    always_comb begin
        grid_nxt = NO_NEIGHBOR;
        col_step = col_reg;
        case (dir_reg)
            DIR_UP:   if (up_sum < {1'b0, n}) grid_nxt = up_sum[IDX_W-1:0];
            DIR_DOWN: if (idx_reg >= ppr_reg) grid_nxt = idx_reg - ppr_reg;
            DIR_LEFT: if (col_reg != '0) begin
                grid_nxt = idx_reg - 1'b1;
                col_step = col_reg - 1'b1;
            end
            DIR_RIGHT: if ((col_reg + 1'b1 != ppr_reg) && (rt_sum < {1'b0, n})) begin
                grid_nxt = rt_sum[IDX_W-1:0];
                col_step = col_reg + 1'b1;
            end
            default: grid_nxt = NO_NEIGHBOR;
        endcase
        if (ppr_reg == '0) grid_nxt = NO_NEIGHBOR;
    end

    assign tab_nxt = (idx_reg < built_n_reg) ? tab_rd_reg[dir_reg] : NO_NEIGHBOR;

    always_comb begin
        state_next    = state_reg;
        pl_next       = pl_reg;
        pl_eff        = (pl_reg >= n) ? '0 : pl_reg;
        built_n_next  = built_n_reg;
        row_next      = row_reg;
        j_next        = j_reg;
        a_next        = a_reg;
        cand_next     = cand_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        cnt2_next     = cnt2_reg;
        dir_next      = dir_reg;
        dir2_next     = dir2_reg;
        col_next      = col_reg;
        res_ok_next   = res_ok_reg;
        res_end_next  = res_end_reg;
        store_we      = 1'b0;
        store_waddr   = pl_eff[ADDR_W-1:0];
        store_raddr   = sj[ADDR_W-1:0];
        tab_we        = 1'b0;
        tab_raddr     = idx_reg[ADDR_W-1:0];
        col_start     = 1'b0;
        out_load      = 1'b0;
        for (int d = 0; d < 4; d++) begin
            who_next[d] = who_reg[d];
            best_we[d]  = 1'b0;
        end

        case (state_reg)
            ST_IDLE: if (s_acc) begin
                if (in_cmd == CMD_LOAD) begin
                    if (n != '0) begin
                        store_we = 1'b1;
                        if (pl_eff + 1'b1 == n) begin
                            pl_next    = '0;
                            row_next   = '0;
                            state_next = ST_BROW;
                        end else begin
                            pl_next = pl_eff + 1'b1;
                        end
                    end
                end else begin
                    idx_next  = in_start;
                    cnt2_next = '0;
                    dir2_next = DIR_DOWN;
                    case (in_cmd)
                        CMD_OFFSET: begin
                            cnt_next  = in_ox[IDX_W-1] ? IDX_W'(-in_ox) : IDX_W'(in_ox);
                            dir_next  = (in_ox > 0) ? DIR_RIGHT : DIR_LEFT;
                            cnt2_next = in_oy[IDX_W-1] ? IDX_W'(-in_oy) : IDX_W'(in_oy);
                            dir2_next = (in_oy > 0) ? DIR_UP : DIR_DOWN;
                        end
                        CMD_ALT_X: begin
                            cnt_next = in_start >> 1;
                            dir_next = in_start[0] ? DIR_RIGHT : DIR_LEFT;
                        end
                        default: begin
                            cnt_next = in_start >> 1;
                            dir_next = in_start[0] ? DIR_UP : DIR_DOWN;
                        end
                    endcase
                    if (rect_reg && ppr_reg != '0) begin
                        col_start  = 1'b1;
                        state_next = ST_WCOL;
                    end else begin
                        state_next = ST_WSTEP;
                    end
                end
            end
            ST_BROW: begin
                store_raddr = si[ADDR_W-1:0];
                j_next      = '0;
                state_next  = ST_BROWW;
            end
            ST_BROWW: begin
                a_next = store_rd_reg;
                for (int d = 0; d < 4; d++) who_next[d] = NO_NEIGHBOR;
                state_next = ST_BRD;
            end
            ST_BRD: begin
                if (j_reg == row_reg) begin
                    if (j_reg + 1'b1 == n) state_next = ST_BWR;
                    else j_next = j_reg + 1'b1;
                end else begin
                    state_next = ST_BCAP;
                end
            end
            ST_BCAP: begin
                cand_next[DIR_UP]    = (adx <= DIFF_W'(tol_reg)) && (ay < by);
                cand_next[DIR_DOWN]  = (adx <= DIFF_W'(tol_reg)) && (ay > by);
                cand_next[DIR_LEFT]  = (ady <= DIFF_W'(tol_reg)) && (ax > bx);
                cand_next[DIR_RIGHT] = (ady <= DIFF_W'(tol_reg)) && (ax < bx);
                state_next = ST_BDIST;
            end
            ST_BDIST: if (sq_done) begin
                // strict less keeps the lower index on a tie
                for (int d = 0; d < 4; d++) begin
                    if (cand_reg[d] && (who_reg[d] == NO_NEIGHBOR || sq_sum < best_reg[d])) begin
                        who_next[d] = j_reg;
                        best_we[d]  = 1'b1;
                    end
                end
                if (j_reg + 1'b1 == n) begin
                    state_next = ST_BWR;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_BRD;
                end
            end
            ST_BWR: begin
                tab_we = 1'b1;
                if (row_reg + 1'b1 == n) begin
                    built_n_next = n;
                    state_next   = ST_IDLE;
                end else begin
                    row_next   = row_reg + 1'b1;
                    state_next = ST_BROW;
                end
            end
            ST_WCOL: if (col_done) begin
                col_next   = col_rem;
                state_next = ST_WSTEP;
            end
            ST_WSTEP: begin
                if (cnt_reg == '0) begin
                    if (cnt2_reg != '0) begin
                        cnt_next  = cnt2_reg;
                        dir_next  = dir2_reg;
                        cnt2_next = '0;
                    end else begin
                        res_ok_next  = 1'b1;
                        res_end_next = idx_reg;
                        state_next   = ST_FIN;
                    end
                end else if (idx_reg >= n || (rect_reg && grid_nxt == NO_NEIGHBOR)) begin
                    res_ok_next  = 1'b0;
                    res_end_next = NO_NEIGHBOR;
                    state_next   = ST_FIN;
                end else if (rect_reg) begin
                    idx_next = grid_nxt;
                    col_next = col_step;
                    cnt_next = cnt_reg - 1'b1;
                end else begin
                    state_next = ST_WTAB;
                end
            end
            ST_WTAB: begin
                if (tab_nxt == NO_NEIGHBOR) begin
                    res_ok_next  = 1'b0;
                    res_end_next = NO_NEIGHBOR;
                    state_next   = ST_FIN;
                end else begin
                    idx_next   = tab_nxt;
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_WSTEP;
                end
            end
            ST_FIN: if (!m_tvalid_reg || m_tready) begin
                out_load   = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        if (out_load) m_tvalid_next = 1'b1;
        else if (m_tready) m_tvalid_next = 1'b0;
        else m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pl_reg       <= '0;
            built_n_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            rect_reg     <= 1'b0;
            ppr_reg      <= '0;
            pcount_reg   <= '0;
            rev_reg      <= 1'b0;
            tol_reg      <= TOL_W'(16);
        end else begin
            state_reg    <= state_next;
            pl_reg       <= pl_next;
            built_n_reg  <= built_n_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_RECT_MODE: rect_reg   <= cfg_wdata[0];
                    CFG_PPR:       ppr_reg    <= cfg_wdata[IDX_W-1:0];
                    CFG_PCOUNT:    pcount_reg <= cfg_wdata[IDX_W-1:0];
                    CFG_REVERSE:   rev_reg    <= cfg_wdata[0];
                    CFG_TOL:       tol_reg    <= cfg_wdata[TOL_W-1:0];
                    default: ;
                endcase
            end
        end
        row_reg     <= row_next;
        j_reg       <= j_next;
        a_reg       <= a_next;
        cand_reg    <= cand_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        cnt2_reg    <= cnt2_next;
        dir_reg     <= dir_next;
        dir2_reg    <= dir2_next;
        col_reg     <= col_next;
        res_ok_reg  <= res_ok_next;
        res_end_reg <= res_end_next;
        for (int d = 0; d < 4; d++) begin
            who_reg[d] <= who_next[d];
            if (best_we[d]) best_reg[d] <= sq_sum;
        end
        if (out_load) begin
            m_end_reg <= res_end_reg;
            m_ok_reg  <= res_ok_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) store_mem[store_waddr] <= {in_y, in_x};
        store_rd_reg <= store_mem[store_raddr];
    end

    always_ff @(posedge aclk) begin
        if (tab_we) begin
            tab_up_mem[row_reg[ADDR_W-1:0]] <= who_reg[DIR_UP];
            tab_dn_mem[row_reg[ADDR_W-1:0]] <= who_reg[DIR_DOWN];
            tab_lf_mem[row_reg[ADDR_W-1:0]] <= who_reg[DIR_LEFT];
            tab_rt_mem[row_reg[ADDR_W-1:0]] <= who_reg[DIR_RIGHT];
        end
        tab_rd_reg[DIR_UP]    <= tab_up_mem[tab_raddr];
        tab_rd_reg[DIR_DOWN]  <= tab_dn_mem[tab_raddr];
        tab_rd_reg[DIR_LEFT]  <= tab_lf_mem[tab_raddr];
        tab_rd_reg[DIR_RIGHT] <= tab_rt_mem[tab_raddr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, m_ok_reg, m_end_reg};

`ifndef SYNTHESIS
    a_fail_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[IDX_W] |-> m_tdata[IDX_W-1:0] == NO_NEIGHBOR)
        else $error("failed walk without no-neighbour code");

    a_sq_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_done |-> state_reg == ST_BDIST)
        else $error("squared distance outside build compare");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WSTEP && rect_reg && ppr_reg != '0 |-> col_reg < ppr_reg)
        else $error("grid column out of range");

    a_built_n: assert property (@(posedge aclk) disable iff (!aresetn)
        built_n_reg <= IDX_W'(MAX_PIXELS))
        else $error("built group size too large");
`endif
endmodule

>>> tb/sv/grid_neighbor_index_walker_tb.sv
`timescale 1ns / 1ps
module grid_neighbor_index_walker_tb;
    import gniw_pkg::*;

    localparam int CYCLE_LIMIT = 8_000_000;

    typedef struct {
        logic [IDX_W-1:0] end_index;
        logic             walk_ok;
    } walk_res_t;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_ADDR_W-1:0]  addr;
        logic [CFG_DATA_W-1:0]  value;
        cmd_t                   cmd;
        logic [15:0]            px;
        logic [15:0]            py;
        logic [IDX_W-1:0]       start;
        logic [10:0]            ox;
        logic [10:0]            oy;
        bit                     typed;
        logic [IDX_W-1:0]       exp_end;
        logic                   exp_ok;
    } row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [71:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    grid_neighbor_index_walker u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // shadow copy of the block
    logic        rect_mode = 1'b0;
    int unsigned row_width = 0;
    int unsigned group_pixels = 0;
    logic        reversed = 1'b0;
    int unsigned tolerance = 16;
    int          pt_x [MAX_PIXELS];
    int          pt_y [MAX_PIXELS];
    logic [IDX_W-1:0] nb_up [MAX_PIXELS];
    logic [IDX_W-1:0] nb_dn [MAX_PIXELS];
    logic [IDX_W-1:0] nb_lf [MAX_PIXELS];
    logic [IDX_W-1:0] nb_rt [MAX_PIXELS];
    int unsigned loaded = 0;
    int unsigned last_build_n = 0;

    walk_res_t pending_walks[$];
    row_t      dir_rows[$];
    int        mismatches = 0;
    int        tx_idle = 0;
    int        rx_idle = 0;
    longint    cycles = 0;

    function automatic int unsigned active_n();
        return group_pixels < MAX_PIXELS ? group_pixels : MAX_PIXELS;
    endfunction

    function automatic void build_neighbours(int unsigned n);
        int si, sj;
        longint ddx, ddy, sq_dist;
        longint best [4];
        logic [IDX_W-1:0] who [4];
        for (int i = 0; i < MAX_PIXELS; i++) begin
            nb_up[i] = NO_NEIGHBOR; nb_dn[i] = NO_NEIGHBOR;
            nb_lf[i] = NO_NEIGHBOR; nb_rt[i] = NO_NEIGHBOR;
        end
        for (int i = 0; i < n; i++) begin
            si = reversed ? n - 1 - i : i;
            for (int d = 0; d < 4; d++) begin
                best[d] = 64'h7FFF_FFFF_FFFF_FFFF;
                who[d] = NO_NEIGHBOR;
            end
            for (int j = 0; j < n; j++) begin
                if (i == j) continue;
                sj = reversed ? n - 1 - j : j;
                ddx = pt_x[si] - pt_x[sj];
                ddy = pt_y[si] - pt_y[sj];
                if (ddx < 0) ddx = -ddx;
                if (ddy < 0) ddy = -ddy;
                sq_dist = ddx * ddx + ddy * ddy;
                if (ddx <= tolerance) begin
                    if (pt_y[si] < pt_y[sj] && sq_dist < best[DIR_UP]) begin
                        best[DIR_UP] = sq_dist; who[DIR_UP] = j;
                    end else if (pt_y[si] > pt_y[sj] && sq_dist < best[DIR_DOWN]) begin
                        best[DIR_DOWN] = sq_dist; who[DIR_DOWN] = j;
                    end
                end
                if (ddy <= tolerance) begin
                    if (pt_x[si] > pt_x[sj] && sq_dist < best[DIR_LEFT]) begin
                        best[DIR_LEFT] = sq_dist; who[DIR_LEFT] = j;
                    end else if (pt_x[si] < pt_x[sj] && sq_dist < best[DIR_RIGHT]) begin
                        best[DIR_RIGHT] = sq_dist; who[DIR_RIGHT] = j;
                    end
                end
            end
            nb_up[i] = who[DIR_UP]; nb_dn[i] = who[DIR_DOWN];
            nb_lf[i] = who[DIR_LEFT]; nb_rt[i] = who[DIR_RIGHT];
        end
    endfunction

    function automatic logic [IDX_W-1:0] neighbour_of(int unsigned idx, dir_t d);
        int unsigned n, r;
        n = active_n();
        r = row_width;
        if (idx >= n) return NO_NEIGHBOR;
        if (rect_mode) begin
            if (r == 0) return NO_NEIGHBOR;
            case (d)
                DIR_UP:   return idx + r < n ? idx + r : NO_NEIGHBOR;
                DIR_DOWN: return idx >= r ? idx - r : NO_NEIGHBOR;
                DIR_LEFT: return (idx % r) != 0 ? idx - 1 : NO_NEIGHBOR;
                default:  return ((idx + 1) % r) != 0 && idx + 1 < n ? idx + 1 : NO_NEIGHBOR;
            endcase
        end
        case (d)
            DIR_UP:   return nb_up[idx];
            DIR_DOWN: return nb_dn[idx];
            DIR_LEFT: return nb_lf[idx];
            default:  return nb_rt[idx];
        endcase
    endfunction

    function automatic void walk_steps(inout logic [IDX_W-1:0] idx, inout logic ok,
                                       input int unsigned count, input dir_t d);
        for (int unsigned k = 0; k < count && ok; k++) begin
            idx = neighbour_of(idx, d);
            if (idx == NO_NEIGHBOR) ok = 1'b0;
        end
    endfunction

    // updates the shadow state; returns 1 when the request yields a result
    function automatic bit predict_walk(input logic [71:0] d, output walk_res_t res);
        cmd_t c;
        logic [IDX_W-1:0] idx;
        logic ok;
        int ox, oy;
        int unsigned n;
        c = d[1:0];
        idx = d[44:34];
        ox = $signed(d[55:45]);
        oy = $signed(d[66:56]);
        ok = 1'b1;
        if (c == CMD_LOAD) begin
            n = active_n();
            if (n == 0) return 0;
            if (loaded >= n) loaded = 0;
            pt_x[loaded] = $signed(d[17:2]);
            pt_y[loaded] = $signed(d[33:18]);
            loaded++;
            if (loaded == n) begin
                build_neighbours(n);
                loaded = 0;
                last_build_n = n;
            end
            return 0;
        end
        if (c == CMD_OFFSET) begin
            walk_steps(idx, ok, ox < 0 ? -ox : ox, ox > 0 ? DIR_RIGHT : DIR_LEFT);
            if (ok) walk_steps(idx, ok, oy < 0 ? -oy : oy, oy > 0 ? DIR_UP : DIR_DOWN);
        end else if (c == CMD_ALT_X) begin
            walk_steps(idx, ok, idx / 2, idx[0] ? DIR_RIGHT : DIR_LEFT);
        end else begin
            walk_steps(idx, ok, idx / 2, idx[0] ? DIR_UP : DIR_DOWN);
        end
        res.end_index = ok ? idx : NO_NEIGHBOR;
        res.walk_ok = ok;
        return 1;
    endfunction

    function automatic logic [71:0] pack_req(cmd_t c, logic [15:0] px, logic [15:0] py,
                                             logic [10:0] st, logic [10:0] ox,
                                             logic [10:0] oy);
        return {5'b0, oy, ox, st, py, px, c};
    endfunction

    // send one request; returns with the handshake just taken
    task automatic send_req(input logic [71:0] d, input bit typed, input walk_res_t typed_res);
        walk_res_t res;
        while ($urandom_range(0, 99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        if (predict_walk(d, res)) pending_walks.push_back(typed ? typed_res : res);
    endtask

    task automatic drain();
        int unsigned holdoff;
        s_tvalid <= 1'b0;
        while (pending_walks.size() != 0) @(posedge aclk);
        // a table build may still be running behind the last load
        holdoff = 6 * last_build_n * last_build_n + 3 * last_build_n + 64;
        repeat (holdoff) @(posedge aclk);
        last_build_n = 0;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input int unsigned v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (a)
            CFG_RECT_MODE: rect_mode = v[0];
            CFG_PPR:       row_width = v & 11'h7FF;
            CFG_PCOUNT:    group_pixels = v & 11'h7FF;
            CFG_REVERSE:   reversed = v[0];
            CFG_TOL:       tolerance = v & 16'hFFFF;
            default: ;
        endcase
    endtask

    task automatic add_item(cmd_t c, logic [15:0] px, logic [15:0] py, logic [10:0] st,
                            logic [10:0] ox, logic [10:0] oy, bit typed,
                            logic [10:0] e, logic ok);
        row_t r;
        r = '{ROW_ITEM, '0, '0, c, px, py, st, ox, oy, typed, e, ok};
        dir_rows.push_back(r);
    endtask

    task automatic add_cfg(logic [CFG_ADDR_W-1:0] a, logic [15:0] v);
        row_t r;
        r = '{ROW_CFG, a, v, CMD_LOAD, '0, '0, '0, '0, '0, 1'b0, '0, 1'b0};
        dir_rows.push_back(r);
    endtask

    task automatic random_episode(input int unsigned walks);
        walk_res_t none;
        int unsigned n, nloads, sel;
        logic [15:0] px, py;
        logic [10:0] st, ox, oy;
        cmd_t c;
        none = '{'0, 1'b0};
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            write_reg(CFG_RECT_MODE, 1);
            n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1024) : $urandom_range(1, 40);
            write_reg(CFG_PCOUNT, n);
            write_reg(CFG_PPR, $urandom_range(0, 9) == 0 ? $urandom_range(0, 1024)
                                                         : $urandom_range(0, 8));
        end else begin
            write_reg(CFG_RECT_MODE, 0);
            n = $urandom_range(0, 19) == 0 ? $urandom_range(24, 48) : $urandom_range(0, 12);
            write_reg(CFG_PCOUNT, n);
            write_reg(CFG_REVERSE, $urandom_range(0, 1));
            write_reg(CFG_TOL, $urandom_range(0, 9) == 0 ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, 40));
            // mostly a full group, sometimes short or over-long
            nloads = $urandom_range(0, 4) == 0 ? $urandom_range(0, 2 * n + 1) : n;
            for (int k = 0; k < nloads; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    px = $urandom_range(0, 65535);
                    py = $urandom_range(0, 65535);
                end else begin
                    px = $urandom_range(0, 5) * 16 + $urandom_range(0, 6) - 3;
                    py = $urandom_range(0, 5) * 16 + $urandom_range(0, 6) - 3;
                end
                send_req(pack_req(CMD_LOAD, px, py, $urandom_range(0, 2047),
                                  $urandom_range(0, 2047), $urandom_range(0, 2047)),
                         0, none);
            end
        end
        for (int k = 0; k < walks; k++) begin
            c = $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0 && $urandom_range(0, 9) == 0) c = CMD_LOAD;
            st = $urandom_range(0, 7) == 0 ? $urandom_range(0, 2047)
                                           : $urandom_range(0, n + 1);
            if ($urandom_range(0, 7) == 0) begin
                ox = $urandom_range(0, 2047);
                oy = $urandom_range(0, 2047);
            end else begin
                ox = $urandom_range(0, 8) - 4;
                oy = $urandom_range(0, 8) - 4;
            end
            send_req(pack_req(c, $urandom_range(0, 65535), $urandom_range(0, 65535),
                              st, ox, oy), 0, none);
        end
    endtask

    always @(posedge aclk) begin
        walk_res_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_walks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result end=%0d ok=%0b", m_tdata[10:0], m_tdata[11]);
            end else begin
                want = pending_walks.pop_front();
                if (m_tdata[10:0] !== want.end_index || m_tdata[11] !== want.walk_ok) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected end=%0d ok=%0b, got end=%0d ok=%0b",
                                 want.end_index, want.walk_ok, m_tdata[10:0], m_tdata[11]);
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= rx_idle);
    end

    initial begin
        walk_res_t tr;
        row_t r;
        build_neighbours(0);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty group straight after reset
        add_item(CMD_OFFSET, 0, 0, 0, 0, 0, 1, 0, 1);
        add_item(CMD_OFFSET, 0, 0, 2047, 0, 0, 1, 2047, 1);
        add_item(CMD_ALT_X, 0, 0, 2047, 0, 0, 1, NO_NEIGHBOR, 0);
        add_item(CMD_OFFSET, 0, 0, 0, 11'd1, 0, 1, NO_NEIGHBOR, 0);
        add_item(CMD_LOAD, 16'h8000, 16'h7FFF, 0, 0, 0, 0, 0, 0);
        // 4-wide grid of 16
        add_cfg(CFG_RECT_MODE, 1);
        add_cfg(CFG_PPR, 4);
        add_cfg(CFG_PCOUNT, 16);
        add_item(CMD_OFFSET, 0, 0, 0, 11'd3, 11'd3, 1, 15, 1);
        add_item(CMD_OFFSET, 0, 0, 0, 11'h7FF, 0, 1, NO_NEIGHBOR, 0);
        add_item(CMD_OFFSET, 0, 0, 5, 11'h400, 11'h3FF, 0, 0, 0);
        add_item(CMD_ALT_Y, 0, 0, 7, 0, 0, 0, 0, 0);
        add_cfg(CFG_PPR, 0);
        add_item(CMD_OFFSET, 0, 0, 1, 11'd1, 0, 1, NO_NEIGHBOR, 0);
        add_cfg(CFG_PPR, 1024);
        add_cfg(CFG_PCOUNT, 1024);
        add_item(CMD_OFFSET, 0, 0, 1023, 11'h401, 0, 0, 0, 0);
        // point list, reversed, zero tolerance, then a shrink mid-pass
        add_cfg(CFG_RECT_MODE, 0);
        add_cfg(CFG_PCOUNT, 4);
        add_cfg(CFG_REVERSE, 1);
        add_cfg(CFG_TOL, 0);
        add_item(CMD_LOAD, 16'h8000, 16'h8000, 0, 0, 0, 0, 0, 0);
        add_item(CMD_LOAD, 16'h8000, 16'h7FFF, 0, 0, 0, 0, 0, 0);
        add_item(CMD_LOAD, 16'h7FFF, 16'h8000, 0, 0, 0, 0, 0, 0);
        add_cfg(CFG_PCOUNT, 2);
        add_item(CMD_LOAD, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0, 0, 0);
        add_item(CMD_LOAD, 16'h7FFF, 16'h0000, 0, 0, 0, 0, 0, 0);
        add_item(CMD_ALT_Y, 0, 0, 3, 0, 0, 0, 0, 0);
        add_item(CMD_OFFSET, 0, 0, 1, 11'h7FF, 11'h001, 0, 0, 0);
        add_cfg(CFG_TOL, 16'hFFFF);

        tx_idle = 19;
        rx_idle = 63;
        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            if (r.kind == ROW_CFG) begin
                write_reg(r.addr, r.value);
            end else begin
                tr = '{r.exp_end, r.exp_ok};
                send_req(pack_req(r.cmd, r.px, r.py, r.start, r.ox, r.oy), r.typed, tr);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle = phase == 0 ? 19 : (phase == 1 ? 63 : 0);
            rx_idle = phase == 0 ? 63 : (phase == 1 ? 19 : 0);
            for (int e = 0; e < 45; e++) random_episode($urandom_range(6, 14));
        end

        drain();
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && pending_walks.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

>>> filelist.f
sv/gniw_pkg.sv
sv/gniw_sqdist.sv
sv/gniw_colrem.sv
sv/grid_neighbor_index_walker.sv
tb/sv/grid_neighbor_index_walker_tb.sv
